@@ design/rse_pkg.sv @@
// Shared types, character codes and helpers for the RPN stack evaluator.
// No dependencies; used by every module of the block except rse_ram.
`timescale 1ns / 1ps

package rse_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_UNDER = 2'd2,
        ERR_OVER  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_DIGIT = 2'd1,
        CLS_COMMA = 2'd2,
        CLS_OP    = 2'd3
    } cls_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } sym_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               error_code;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic digit;
        logic push_acc;
        logic clear_acc;
        logic underflow;
        logic rd_issue;
        logic alu_write;
        logic div_zero;
        logic div_start;
        logic div_write;
        logic emit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cls_t cls;
        logic pwd;
        logic lt2;
        logic op_div;
        logic b_zero;
        logic div_done;
        logic last;
        logic out_free;
    } dp_stat_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if (c inside {[CH_ZERO:CH_NINE]})
            r = CLS_DIGIT;
        else if (c == CH_COMMA)
            r = CLS_COMMA;
        else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH})
            r = CLS_OP;
        else
            r = CLS_OTHER;
        return r;
    endfunction

    // first error of an expression wins
    function automatic err_t sticky(input err_t cur, input err_t code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

@@ design/rse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/rse_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rse_pkg. Divisor must be nonzero (caller filters zero).
`timescale 1ns / 1ps

module rse_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rse_pkg::DATA_W-1:0] dividend,
    input  logic [rse_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [rse_pkg::DATA_W-1:0] quotient
);

    import rse_pkg::*;

    localparam int SW = $clog2(DATA_W);
    localparam logic [SW-1:0] LAST_STEP = SW'(DATA_W - 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg, step_next;

    logic [DATA_W-1:0] mag_a, mag_b;
    logic [DATA_W:0]   shifted, trial;

    assign mag_a   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    assign mag_b   = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = mag_a;
            dvs_next  = mag_b;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference only when it did not borrow
            rem_next  = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

@@ design/rse_datapath.sv @@
// Datapath: accumulator, operand stack (RAM plus cached top and bottom),
// ALU, divider and the result word register. Depends on rse_pkg, rse_ram, rse_div.
`timescale 1ns / 1ps

module rse_datapath #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rse_pkg::sym_t     sym_data,
    input  rse_pkg::dp_cmd_t  cmd,
    output rse_pkg::dp_stat_t stat,
    output logic              res_valid,
    input  logic              res_ready,
    output rse_pkg::res_t     res_data
);

    import rse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pwd_reg, pwd_next;
    err_t              err_reg, err_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] bottom_reg, bottom_next;
    logic [7:0]        char_reg, char_next;
    cls_t              cls_reg, cls_next;
    logic              last_reg, last_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_data_reg, res_data_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] a_val;
    logic [CW-1:0]     cnt_m2;
    logic [7:0]        digit_w;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] div_q;
    logic              div_done;
    logic [DATA_W-1:0] result;
    logic              res_wr;
    logic              out_free;

    assign cnt_m2   = count_reg - CW'(2);
    assign digit_w  = char_reg - CH_ZERO;
    assign out_free = ~res_valid_reg | res_ready;

    rse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_issue),
        .raddr (cnt_m2[AW-1:0]),
        .rdata (a_val)
    );

    rse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_val),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // a sits in the RAM read register, b in the cached top
    always_comb
    begin
        case (char_reg)
            CH_PLUS:  alu_res = a_val + top_reg;
            CH_MINUS: alu_res = a_val - top_reg;
            CH_STAR:  alu_res = a_val * top_reg;
            default:  alu_res = '0;
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        pwd_next       = pwd_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        char_next      = char_reg;
        cls_next       = cls_reg;
        last_next      = last_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        result         = '0;
        res_wr         = 1'b0;

        if (cmd.capture)
        begin
            char_next = sym_data.char_code;
            cls_next  = classify(sym_data.char_code);
            last_next = sym_data.is_last;
        end

        if (cmd.digit)
        begin
            acc_next = acc_reg * DATA_W'(DEC_BASE) + DATA_W'(digit_w);
            pwd_next = 1'b1;
        end

        if (cmd.push_acc)
        begin
            acc_next = '0;
            pwd_next = 1'b0;
            if (count_reg == CW'(STACK_DEPTH))
            begin
                err_next = sticky(err_reg, ERR_OVER);
            end
            else
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[AW-1:0];
                wr_data    = acc_reg;
                top_next   = acc_reg;
                count_next = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    bottom_next = acc_reg;
                end
            end
        end

        if (cmd.clear_acc)
        begin
            acc_next = '0;
            pwd_next = 1'b0;
        end

        if (cmd.underflow)
        begin
            err_next = sticky(err_reg, ERR_UNDER);
        end

        if (cmd.alu_write)
        begin
            result = alu_res;
            res_wr = 1'b1;
        end

        if (cmd.div_zero)
        begin
            result   = '0;
            res_wr   = 1'b1;
            err_next = sticky(err_reg, ERR_DIV0);
        end

        if (cmd.div_write)
        begin
            result = div_q;
            res_wr = 1'b1;
        end

        // two entries collapse into one at depth count-2
        if (res_wr)
        begin
            wr_en      = 1'b1;
            wr_addr    = cnt_m2[AW-1:0];
            wr_data    = result;
            top_next   = result;
            count_next = count_reg - 1'b1;
            if (cnt_m2 == '0)
            begin
                bottom_next = result;
            end
        end

        if (cmd.emit)
        begin
            res_valid_next           = 1'b1;
            res_data_next.value      = (count_reg != '0) ? bottom_reg : acc_reg;
            res_data_next.error_code = err_reg;
            acc_next                 = '0;
            pwd_next                 = 1'b0;
            err_next                 = ERR_NONE;
            count_next               = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pwd_reg       <= 1'b0;
            err_reg       <= ERR_NONE;
            count_reg     <= '0;
            cls_reg       <= CLS_OTHER;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pwd_reg       <= pwd_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            cls_reg       <= cls_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        bottom_reg   <= bottom_next;
        char_reg     <= char_next;
        res_data_reg <= res_data_next;
    end

    assign stat.cls      = cls_reg;
    assign stat.pwd      = pwd_reg;
    assign stat.lt2      = (count_reg < CW'(2));
    assign stat.op_div   = (char_reg == CH_SLASH);
    assign stat.b_zero   = (top_reg == '0);
    assign stat.div_done = div_done;
    assign stat.last     = last_reg;
    assign stat.out_free = out_free;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !cmd.emit) |=> (err_reg == $past(err_reg)))
        else $error("sticky error overwritten");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0 && acc_reg == '0 && err_reg == ERR_NONE && res_valid))
        else $error("state not cleared after emit");

    a_collapse: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("operator result did not pop one entry");
`endif

endmodule

@@ design/rse_ctrl.sv @@
// Controller FSM: sequences capture, push, stack read, ALU/divide and emit.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sym_valid,
    output logic              sym_ready,
    input  rse_pkg::dp_stat_t stat,
    output rse_pkg::dp_cmd_t  cmd
);

    import rse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_OPER   = 6'b001000,
        S_DIVW   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        sym_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sym_ready = 1'b1;
                if (sym_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cls)
                    CLS_DIGIT:
                    begin
                        cmd.digit  = 1'b1;
                        state_next = S_FINISH;
                    end
                    CLS_COMMA:
                    begin
                        cmd.push_acc = 1'b1;
                        state_next   = S_FINISH;
                    end
                    CLS_OP:
                    begin
                        // pending number goes on the stack before the operands are read
                        if (stat.pwd)
                            cmd.push_acc = 1'b1;
                        else
                            cmd.clear_acc = 1'b1;
                        state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_READ:
            begin
                if (stat.lt2)
                begin
                    cmd.underflow = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_OPER;
                end
            end
            S_OPER:
            begin
                if (!stat.op_div)
                begin
                    cmd.alu_write = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (stat.b_zero)
                begin
                    cmd.div_zero = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIVW))
        else $error("divide started without waiting for it");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (stat.last && stat.out_free))
        else $error("emit without last word or free output");
`endif

endmodule

@@ design/rpn_stack_evaluator_top.sv @@
// RPN stack evaluator top level: controller plus datapath.
// Depends on rse_pkg, rse_ctrl, rse_datapath.
`timescale 1ns / 1ps

// Usage:
// The sym channel takes one ASCII character word per handshake (char_code,
// is_last). Digits fold into a decimal accumulator, a comma pushes it, and
// + - * / combine the top two stack entries (a pending number is pushed first).
// Other bytes are ignored. The res channel returns one word per expression,
// after the word marked is_last: the bottom stack entry (or the accumulator
// if the stack is empty) and a sticky error code.
// Throughput: one character at a time. Digit, comma and ignored bytes pass
// through decode and finish before the next accept; + - * also pass through
// a stack RAM read of the lower operand; / also waits for the divider, which
// yields one quotient bit per cycle.
// Output: the result word is loaded into the output register from the finish
// state of the last character, once the output register is free.
// A result waiting in the output register does not block new characters;
// only the next result waits (sym_ready stays low) until res_ready drains it.
// Reset: empty stack, zero accumulator, no error, no result pending.
// The stack holds STACK_DEPTH entries; a push onto a full stack is dropped.

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_ready,
    input  rse_pkg::sym_t sym_data,
    output logic          res_valid,
    input  logic          res_ready,
    output rse_pkg::res_t res_data
);

    import rse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_data  (sym_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
